### sv/bpqe_pkg.sv
// Shared types, widths and codes for the bounded priority queue.
package bpqe_pkg;

  localparam int TAG_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int LIMIT_W = 5;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_STORED  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EVICTED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_DROPPED = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_NO_PUSH = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic              retain;
  } entry_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    entry_t new_entry;
  } cell_ctrl_t;

  // What each cell reports back about itself.
  typedef struct packed {
    logic             ge;
    logic             last_lower;
    logic [TAG_W-1:0] last_tag;
  } cell_stat_t;

endpackage

### sv/bpqe_if.sv
// Handshake channel interfaces for requests, results and configuration.
interface bpqe_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bpqe_pkg::TAG_W-1:0]    message_tag;
  logic [bpqe_pkg::PRIO_W-1:0]   priority_req;
  logic                          retain;
  logic                          link_up;

  modport source (output valid, op, message_tag, priority_req, retain, link_up,
                  input ready);
  modport sink   (input valid, op, message_tag, priority_req, retain, link_up,
                  output ready);
endinterface

interface bpqe_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_valid;
  logic [bpqe_pkg::TAG_W-1:0]    out_tag;
  logic [bpqe_pkg::PRIO_W-1:0]   out_priority;
  logic                          out_retain;
  logic [bpqe_pkg::STAT_W-1:0]   push_status;
  logic [bpqe_pkg::TAG_W-1:0]    evicted_tag;
  logic [bpqe_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, out_valid, out_tag, out_priority, out_retain,
                  push_status, evicted_tag, occupancy, input ready);
  modport sink   (input valid, out_valid, out_tag, out_priority, out_retain,
                  push_status, evicted_tag, occupancy, output ready);
endinterface

interface bpqe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpqe_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/bpqe_cell.sv
// One slot of the sorted queue: holds an entry and shifts left or right.
module bpqe_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                 clk,
  input  bpqe_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]        count,
  input  bpqe_pkg::entry_t     left_entry,
  input  logic                 left_ge,
  input  bpqe_pkg::entry_t     right_entry,
  output bpqe_pkg::entry_t     entry,
  output bpqe_pkg::cell_stat_t stat
);

  logic occupied;
  logic is_last;

  assign occupied = count > CW'(IDX);
  assign is_last  = count == CW'(IDX + 1);

  // Sorted order makes the ge flags a run of ones from the head.
  assign stat.ge         = occupied && (entry.prio >= ctrl.new_entry.prio);
  assign stat.last_lower = is_last && (ctrl.new_entry.prio > entry.prio);
  assign stat.last_tag   = is_last ? entry.tag : '0;

  always_ff @(posedge clk) begin
    if (ctrl.push_en) begin
      if (!stat.ge) begin
        entry <= left_ge ? ctrl.new_entry : left_entry;
      end
    end else if (ctrl.pop_en) begin
      entry <= right_entry;
    end
  end

endmodule

### sv/bounded_priority_queue_evict_lowest_core.sv
// Top level of the bounded priority queue with lowest-entry eviction.
//
// The queue is a chain of QUEUE_DEPTH cells kept in priority order, highest
// at cell 0 and, among equal priorities, oldest first. Every cell compares
// its own priority with an incoming push in parallel, so an insert, an
// eviction of the tail entry or a pop of the head is done by one
// compare-and-shift across the cell chain: the block takes one
// transaction per cycle and shows its result in an output register.
// The request side stalls only while a result waits in the output
// register and is not being drained in the same cycle. Every request
// transaction gives exactly one result transaction. The limit register
// may be written at any time the block is idle and is always ready; zero
// acts as one, and values above the depth act as the depth. Cell contents
// are not cleared at reset; the entry count alone says which cells hold
// entries.
module bounded_priority_queue_evict_lowest_core #(
  parameter int QUEUE_DEPTH = bpqe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  bpqe_in_if.sink            req,
  bpqe_out_if.source         rsp,
  bpqe_cfg_if.sink           cfg
);

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > bpqe_pkg::LIMIT_W) ? CW : bpqe_pkg::LIMIT_W;

  logic [bpqe_pkg::LIMIT_W-1:0] queue_limit;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;

  bpqe_pkg::cell_ctrl_t ctrl;
  bpqe_pkg::entry_t     entries [QUEUE_DEPTH];
  bpqe_pkg::cell_stat_t stats   [QUEUE_DEPTH];

  logic accept;
  logic full;
  logic evict_ok;
  logic pop_ok;
  logic [bpqe_pkg::TAG_W-1:0] evict_tag;

  // The configuration register is always able to take a write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= bpqe_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      queue_limit <= cfg.data;
    end
  end

  // A new transaction is taken whenever the output register is free or
  // is being emptied in this cycle.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Full when the count has reached the effective limit. A zero limit acts
  // as one, which the non-empty term covers.
  assign full = (count == CW'(QUEUE_DEPTH)) ||
                ((count != '0) && (CMPW'(count) >= CMPW'(queue_limit)));

  // The tail entry's flags are spread over the cells; gather them here.
  always_comb begin
    evict_ok  = 1'b0;
    evict_tag = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      evict_ok  = evict_ok | stats[i].last_lower;
      evict_tag = evict_tag | stats[i].last_tag;
    end
  end

  assign pop_ok = req.link_up && (count != '0);

  assign ctrl.new_entry.tag    = req.message_tag;
  assign ctrl.new_entry.prio   = req.priority_req;
  assign ctrl.new_entry.retain = req.retain;
  assign ctrl.push_en = accept && (req.op == bpqe_pkg::OP_PUSH) && (!full || evict_ok);
  assign ctrl.pop_en  = accept && (req.op == bpqe_pkg::OP_POP) && pop_ok;

  // The chain of cells. Cell 0 sees an always-true ge on its left so that a
  // push that outranks everything lands at the head.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    bpqe_pkg::entry_t left_e;
    bpqe_pkg::entry_t right_e;
    logic             left_g;

    if (g == 0) begin : g_head
      assign left_e = ctrl.new_entry;
      assign left_g = 1'b1;
    end else begin : g_body
      assign left_e = entries[g-1];
      assign left_g = stats[g-1].ge;
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = entries[g];
    end else begin : g_inner
      assign right_e = entries[g+1];
    end

    bpqe_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_entry  (left_e),
      .left_ge     (left_g),
      .right_entry (right_e),
      .entry       (entries[g]),
      .stat        (stats[g])
    );
  end

  // An eviction leaves the count as it is; only a plain store grows it.
  always_comb begin
    count_next = count;
    if (ctrl.push_en && !full) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop_en) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register: valid is control state, the payload follows accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_valid    <= ctrl.pop_en;
      rsp.out_tag      <= ctrl.pop_en ? entries[0].tag : '0;
      rsp.out_priority <= ctrl.pop_en ? entries[0].prio : '0;
      rsp.out_retain   <= ctrl.pop_en ? entries[0].retain : 1'b0;
      rsp.occupancy    <= bpqe_pkg::OCC_W'(count_next);
      if (req.op == bpqe_pkg::OP_POP) begin
        rsp.push_status <= bpqe_pkg::STATUS_NO_PUSH;
        rsp.evicted_tag <= '0;
      end else if (!full) begin
        rsp.push_status <= bpqe_pkg::STATUS_STORED;
        rsp.evicted_tag <= '0;
      end else if (evict_ok) begin
        rsp.push_status <= bpqe_pkg::STATUS_EVICTED;
        rsp.evicted_tag <= evict_tag;
      end else begin
        rsp.push_status <= bpqe_pkg::STATUS_DROPPED;
        rsp.evicted_tag <= '0;
      end
    end
  end

endmodule
